FILE: rtl/utwm_pkg.sv
// utwm_pkg: shared widths, opcodes, register indexes and the structs that
// pass between the top level and the glyph search unit.
// no dependencies; compile first.
package utwm_pkg;

  localparam int MAX_GLYPHS_DEF = 256;

  localparam int OPC_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 8;
  localparam int CODE_W     = 31;
  localparam int ADV_W      = 8;
  localparam int COUNT_W    = 9;
  localparam int LH_W       = 8;
  localparam int SUM_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // opcodes
  localparam logic [OPC_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OPC_W-1:0] OP_TEXT = 2'd1;
  localparam logic [OPC_W-1:0] OP_END  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 1'd1;

  // glyph table write
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] code;
    logic [ADV_W-1:0]  width;
  } glyph_wr_t;

  // lookup request
  typedef struct packed {
    logic              start;
    logic [CODE_W-1:0] code;
  } search_req_t;

  // lookup result, valid for one cycle with done
  typedef struct packed {
    logic             done;
    logic             found;
    logic [ADV_W-1:0] width;
  } search_res_t;

endpackage

FILE: rtl/utwm_if.sv
// utwm_in_if and utwm_out_if: valid/ready channels for text transactions
// and for measurement results.
// depends on utwm_pkg.
interface utwm_in_if;
  logic                          valid;
  logic                          ready;
  logic [utwm_pkg::OPC_W-1:0]    opcode;
  logic [utwm_pkg::BYTE_W-1:0]   text_byte;
  logic [utwm_pkg::IDX_W-1:0]    entry_index;
  logic [utwm_pkg::CODE_W-1:0]   entry_code;
  logic [utwm_pkg::ADV_W-1:0]    entry_width;

  modport source (
    output valid, opcode, text_byte, entry_index, entry_code, entry_width,
    input  ready
  );
  modport sink (
    input  valid, opcode, text_byte, entry_index, entry_code, entry_width,
    output ready
  );
endinterface

interface utwm_out_if;
  logic                        valid;
  logic                        ready;
  logic [utwm_pkg::SUM_W-1:0]  text_width;
  logic [utwm_pkg::SUM_W-1:0]  text_height;

  modport source (output valid, text_width, text_height, input ready);
  modport sink (input valid, text_width, text_height, output ready);
endinterface

FILE: rtl/utwm_glyph_search.sv
// utwm_glyph_search: glyph code/width memory and a binary search that does
// one table probe per cycle through the registered read port.
// depends on utwm_pkg.
module utwm_glyph_search #(
  parameter int MAX_GLYPHS = utwm_pkg::MAX_GLYPHS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  utwm_pkg::glyph_wr_t              wr,
  input  utwm_pkg::search_req_t            req,
  input  logic [utwm_pkg::COUNT_W-1:0]     glyph_count,
  output utwm_pkg::search_res_t            res
);

  localparam int AW = $clog2(MAX_GLYPHS);
  localparam int PW = AW + 1;
  localparam int SW = PW + 1;
  localparam int NW = (PW > utwm_pkg::COUNT_W) ? PW : utwm_pkg::COUNT_W;

  logic [utwm_pkg::CODE_W-1:0] mem_code  [MAX_GLYPHS];
  logic [utwm_pkg::ADV_W-1:0]  mem_width [MAX_GLYPHS];

  logic [utwm_pkg::CODE_W-1:0] rd_code;
  logic [utwm_pkg::ADV_W-1:0]  rd_width;
  logic [AW-1:0]               rd_addr;

  logic                        busy;
  logic                        empty;
  logic [PW-1:0]               lo, lo_next;
  logic [PW-1:0]               hi, hi_next;
  logic [AW-1:0]               mid;
  logic [utwm_pkg::CODE_W-1:0] key;

  logic [NW-1:0]               count_ext;
  logic [PW-1:0]               n;
  logic [PW-1:0]               hi_start;
  logic                        stop;

  // clamp the entry count to the table depth
  assign count_ext = NW'(glyph_count);
  assign n         = (count_ext > NW'(MAX_GLYPHS)) ? PW'(MAX_GLYPHS) : PW'(count_ext);
  assign hi_start  = (n == '0) ? '0 : n - PW'(1);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    rd_addr = mid;
    res     = '0;
    stop    = 1'b0;
    if (req.start) begin
      lo_next = '0;
      hi_next = hi_start;
      rd_addr = AW'(hi_start >> 1);
    end else if (busy) begin
      if (empty) begin
        res.done = 1'b1;
      end else if (rd_code == key) begin
        res.done  = 1'b1;
        res.found = 1'b1;
        res.width = rd_width;
      end else begin
        if (rd_code < key) begin
          lo_next = PW'(mid) + PW'(1);
        end else if (mid == '0) begin
          stop = 1'b1;
        end else begin
          hi_next = PW'(mid) - PW'(1);
        end
        if (stop || (lo_next > hi_next)) begin
          res.done = 1'b1;
        end else begin
          rd_addr = AW'((SW'(lo_next) + SW'(hi_next)) >> 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      empty <= 1'b0;
    end else if (req.start) begin
      busy  <= 1'b1;
      empty <= (n == '0);
    end else if (res.done) begin
      busy  <= 1'b0;
    end
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= rd_addr;
    if (req.start) begin
      key <= req.code;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.index) < MAX_GLYPHS)) begin
      mem_code[AW'(wr.index)]  <= wr.code;
      mem_width[AW'(wr.index)] <= wr.width;
    end
    rd_code  <= mem_code[rd_addr];
    rd_width <= mem_width[rd_addr];
  end

endmodule

FILE: rtl/utf8_text_width_measure.sv
// utf8_text_width_measure: top level; UTF-8 decode, line bookkeeping,
// configuration registers and the result register.
// depends on utwm_pkg, utwm_if and utwm_glyph_search.
//
// Measures the extent of a UTF-8 string fed one byte per transaction against
// a glyph table sorted by code point. Table loads (opcode 0), end of string
// (opcode 2), ignored opcode 3, and text bytes that do not complete a code
// point are handled while idle without a search. A byte that completes a
// code point (an ASCII byte or the last byte of a sequence) starts a binary
// search of the table, and no new byte is taken until that search ends. The
// search loop reads the glyph memory once per cycle through its single
// registered read port. The table memory has no reset and no clearing pass;
// only slots that were written may be looked up. The result register lets
// the block keep taking bytes while a result waits; an end of string waits
// only if the previous result has not been taken yet.
module utf8_text_width_measure #(
  parameter int MAX_GLYPHS = utwm_pkg::MAX_GLYPHS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [utwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [utwm_pkg::CFG_DATA_W-1:0]    cfg_data,
  utwm_in_if.sink                            text_in,
  utwm_out_if.source                         extent_out
);

  // sequencer states
  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  // utf-8 lead byte patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] LEAD5_MASK = 8'hFC;
  localparam logic [7:0] LEAD5_VAL  = 8'hF8;
  localparam logic [7:0] LEAD6_MASK = 8'hFE;
  localparam logic [7:0] LEAD6_VAL  = 8'hFC;
  localparam logic [7:0] NEWLINE    = 8'h0A;

  localparam int PEND_W = 3;
  localparam int PROD_W = utwm_pkg::SUM_W + utwm_pkg::LH_W;
  localparam logic [utwm_pkg::SUM_W-1:0] SUM_MAX = '1;

  logic state, state_next;

  // configuration registers
  logic [utwm_pkg::COUNT_W-1:0] glyph_count;
  logic [utwm_pkg::LH_W-1:0]    row_pitch;

  // measuring state
  logic [utwm_pkg::CODE_W-1:0]  code_acc, code_acc_next;
  logic [PEND_W-1:0]            pending, pending_next;
  logic [utwm_pkg::SUM_W-1:0]   cur_width, cur_width_next;
  logic [utwm_pkg::SUM_W-1:0]   widest_line, widest_line_next;
  logic [utwm_pkg::SUM_W-1:0]   line_total, line_total_next;

  // result register
  logic                         out_valid, out_valid_next;
  logic [utwm_pkg::SUM_W-1:0]   out_width;
  logic [utwm_pkg::SUM_W-1:0]   out_height;
  logic                         out_load;

  logic                         accept;
  logic [7:0]                   b;
  logic [utwm_pkg::SUM_W:0]     width_sum;
  logic [PROD_W-1:0]            height_prod;
  logic [utwm_pkg::SUM_W-1:0]   width_max;
  logic [utwm_pkg::SUM_W-1:0]   height_sat;

  utwm_pkg::glyph_wr_t          wr;
  utwm_pkg::search_req_t        req;
  utwm_pkg::search_res_t        res;

  // an end of string needs a free result slot; everything else only idle
  assign text_in.ready = (state == S_IDLE) &&
                         ((text_in.opcode != utwm_pkg::OP_END) ||
                          !out_valid || extent_out.ready);
  assign accept = text_in.valid && text_in.ready;
  assign b      = text_in.text_byte;

  // table writes go straight to the search unit's memory
  assign wr.en    = accept && (text_in.opcode == utwm_pkg::OP_LOAD);
  assign wr.index = text_in.entry_index;
  assign wr.code  = text_in.entry_code;
  assign wr.width = text_in.entry_width;

  // saturating accumulate of a found glyph width
  assign width_sum = {1'b0, cur_width} + (utwm_pkg::SUM_W + 1)'(res.width);

  // result values for end of string
  assign width_max   = (cur_width > widest_line) ? cur_width : widest_line;
  assign height_prod = PROD_W'(line_total) * PROD_W'(row_pitch);
  assign height_sat  = (height_prod[PROD_W-1:utwm_pkg::SUM_W] != '0) ?
                       SUM_MAX : height_prod[utwm_pkg::SUM_W-1:0];

  always_comb begin
    state_next       = state;
    code_acc_next    = code_acc;
    pending_next     = pending;
    cur_width_next   = cur_width;
    widest_line_next = widest_line;
    line_total_next  = line_total;
    out_load         = 1'b0;
    req.start        = 1'b0;
    req.code         = 31'(b);

    if (state == S_SEARCH) begin
      // wait for the lookup, then add the glyph advance
      if (res.done) begin
        state_next = S_IDLE;
        if (res.found) begin
          cur_width_next = width_sum[utwm_pkg::SUM_W] ? SUM_MAX :
                           width_sum[utwm_pkg::SUM_W-1:0];
        end
      end
    end else if (accept) begin
      case (text_in.opcode)
        utwm_pkg::OP_TEXT: begin
          if (pending != '0) begin
            // continuation byte: low six bits shift in, byte not checked
            code_acc_next = {code_acc[utwm_pkg::CODE_W-7:0], b[5:0]};
            pending_next  = pending - PEND_W'(1);
            if (pending == PEND_W'(1)) begin
              req.start  = 1'b1;
              req.code   = code_acc_next;
              state_next = S_SEARCH;
            end
          end else if (b == NEWLINE) begin
            // close the line
            if (cur_width > widest_line) begin
              widest_line_next = cur_width;
            end
            cur_width_next = '0;
            if (line_total != SUM_MAX) begin
              line_total_next = line_total + utwm_pkg::SUM_W'(1);
            end
          end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
            code_acc_next = 31'(b & ~LEAD2_MASK);
            pending_next  = PEND_W'(1);
          end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
            code_acc_next = 31'(b & ~LEAD3_MASK);
            pending_next  = PEND_W'(2);
          end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
            code_acc_next = 31'(b & ~LEAD4_MASK);
            pending_next  = PEND_W'(3);
          end else if ((b & LEAD5_MASK) == LEAD5_VAL) begin
            code_acc_next = 31'(b & ~LEAD5_MASK);
            pending_next  = PEND_W'(4);
          end else if ((b & LEAD6_MASK) == LEAD6_VAL) begin
            code_acc_next = 31'(b & ~LEAD6_MASK);
            pending_next  = PEND_W'(5);
          end else begin
            // ascii, stray continuation or undecodable byte: its own code
            req.start  = 1'b1;
            req.code   = 31'(b);
            state_next = S_SEARCH;
          end
        end
        utwm_pkg::OP_END: begin
          // report and clear; an unfinished sequence is dropped
          out_load         = 1'b1;
          code_acc_next    = '0;
          pending_next     = '0;
          cur_width_next   = '0;
          widest_line_next = '0;
          line_total_next  = utwm_pkg::SUM_W'(1);
        end
        default: begin
          // table load goes through wr; opcode 3 does nothing
        end
      endcase
    end

    out_valid_next = out_load || (out_valid && !extent_out.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      glyph_count <= '0;
      row_pitch   <= '0;
      code_acc    <= '0;
      pending     <= '0;
      cur_width   <= '0;
      widest_line <= '0;
      line_total  <= utwm_pkg::SUM_W'(1);
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      code_acc    <= code_acc_next;
      pending     <= pending_next;
      cur_width   <= cur_width_next;
      widest_line <= widest_line_next;
      line_total  <= line_total_next;
      out_valid   <= out_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          utwm_pkg::REG_GLYPH_COUNT: glyph_count <= cfg_data;
          utwm_pkg::REG_LINE_HEIGHT: row_pitch <= cfg_data[utwm_pkg::LH_W-1:0];
          default: begin
          end
        endcase
      end
    end
    // result payload, no reset needed
    if (out_load) begin
      out_width  <= width_max;
      out_height <= height_sat;
    end
  end

  assign extent_out.valid       = out_valid;
  assign extent_out.text_width  = out_width;
  assign extent_out.text_height = out_height;

  utwm_glyph_search #(
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .req         (req),
    .glyph_count (glyph_count),
    .res         (res)
  );

endmodule
